@@ hdl/mpd_pkg.sv @@
// ============================================================================
// mpd_pkg
// Shared codes and side-band types of the mixed-precision divider pipeline.
// ============================================================================
package mpd_pkg;

    // Mode select codes; the spare code runs as unsigned.
    localparam logic [1:0] FUNC_UNSIGNED  = 2'd0;
    localparam logic [1:0] FUNC_SYMMETRIC = 2'd1;
    localparam logic [1:0] FUNC_FLOORED   = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DIV_ZERO = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;

    // Control that travels with each item down the pipeline.
    typedef struct packed {
        logic       valid;
        logic       sym;     // symmetric mode
        logic       flr;     // floored mode
        logic       qneg;    // negate quotient (symmetric, signs differ)
        logic       rneg;    // negate remainder
        logic       nneg;    // floored: dividend still negative after sign fold
        logic [1:0] status;  // status found so far
    } t_side;

endpackage

@@ hdl/mixed_precision_divider_top.sv @@
// ============================================================================
// mixed_precision_divider_top
// Double-cell by single-cell divider: unsigned, symmetric and floored modes.
// ============================================================================
// Pipeline from the accepting edge to the result strobe: two front stages,
//   one stage per quotient bit, one output stage.
// Throughput: one item per cycle; every stage is a register, so busy stays low.
// The result sits on the ports for exactly one cycle; the receiver cannot stall.
// Reset (synchronous, active low) clears all valid bits and drops items in flight.
module mixed_precision_divider_top #(
    parameter int CELL_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            i_func,
    input  logic [CELL_WIDTH-1:0] i_dividend_high,
    input  logic [CELL_WIDTH-1:0] i_dividend_low,
    input  logic [CELL_WIDTH-1:0] i_divisor,
    output logic                  o_strobe,
    output logic [CELL_WIDTH-1:0] o_quotient,
    output logic [CELL_WIDTH-1:0] o_remainder,
    output logic [1:0]            o_status
);
    import mpd_pkg::*;

    localparam int W   = CELL_WIDTH;
    localparam int LAT = CELL_WIDTH + 3;

    // Chain of per-bit stages; index 0 is the front end's output.
    logic [W-1:0] w_rem  [0:W];
    logic [W-1:0] w_lq   [0:W];
    logic [W-1:0] w_d    [0:W];
    t_side        w_side [0:W];
    logic         w_accept;

    // No stage ever holds back, so an item is taken on every start.
    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    // Fold signs, apply the floored offset, catch zero and range errors.
    mpd_pre #(
        .W(W)
    ) u_pre (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_func  (i_func),
        .i_h     (i_dividend_high),
        .i_l     (i_dividend_low),
        .i_d     (i_divisor),
        .o_h     (w_rem[0]),
        .o_l     (w_lq[0]),
        .o_d     (w_d[0]),
        .o_side  (w_side[0])
    );

    // One quotient bit per stage; the low cell shifts out as quotient bits
    // shift in at the bottom of the same register.
    for (genvar g = 0; g < W; g++) begin : g_step
        mpd_step #(
            .W(W)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_rem   (w_rem[g]),
            .i_lq    (w_lq[g]),
            .i_d     (w_d[g]),
            .i_side  (w_side[g]),
            .o_rem   (w_rem[g+1]),
            .o_lq    (w_lq[g+1]),
            .o_d     (w_d[g+1]),
            .o_side  (w_side[g+1])
        );
    end

    // Restore signs, finish the range check, drive the result ports.
    mpd_post #(
        .W(W)
    ) u_post (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q         (w_lq[W]),
        .i_r         (w_rem[W]),
        .i_side      (w_side[W]),
        .o_strobe    (o_strobe),
        .o_quotient  (o_quotient),
        .o_remainder (o_remainder),
        .o_status    (o_status)
    );

    // Every strobe traces back to an item accepted at the input of the pipeline.
    a_strobe_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(w_accept, LAT))
        else $error("result strobe without a matching accepted item");

    // A zero divisor reports divide by zero, whatever the mode.
    a_div_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_divisor == '0)) |-> ##LAT (o_strobe && (o_status == ST_DIV_ZERO)))
        else $error("zero divisor not reported");

    // A failed item carries zero quotient and remainder.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status != ST_OK)) |-> ((o_quotient == '0) && (o_remainder == '0)))
        else $error("error result with nonzero fields");

    // Only defined status codes leave the block.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ((o_status == ST_OK) || (o_status == ST_DIV_ZERO)
                      || (o_status == ST_RANGE)))
        else $error("undefined status code");

endmodule

@@ hdl/mpd_pre.sv @@
// ============================================================================
// mpd_pre
// Two front stages: fold operand signs per mode, then apply the floored
// offset and check for a zero divisor and an out-of-range quotient.
// ============================================================================
module mpd_pre #(
    parameter int W = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [1:0]    i_func,
    input  logic [W-1:0]  i_h,
    input  logic [W-1:0]  i_l,
    input  logic [W-1:0]  i_d,
    output logic [W-1:0]  o_h,
    output logic [W-1:0]  o_l,
    output logic [W-1:0]  o_d,
    output mpd_pkg::t_side o_side
);
    import mpd_pkg::*;

    logic         w_sym;
    logic         w_flr;
    logic         w_hneg;
    logic         w_dneg;
    logic [2*W-1:0] w_dvd;

    logic [2*W-1:0] r1_dvd;
    logic [W-1:0]   r1_d;
    t_side          r1_side;
    t_side          n1_side;

    logic         w_nneg;
    logic [W-1:0] w_h2;
    t_side        n2_side;
    t_side        r2_side;
    logic [W-1:0] r2_h;
    logic [W-1:0] r2_l;
    logic [W-1:0] r2_d;

    // Stage 1: sign folding.
    always_comb begin
        w_sym  = (i_func == FUNC_SYMMETRIC);
        w_flr  = (i_func == FUNC_FLOORED);
        w_hneg = i_h[W-1];
        w_dneg = i_d[W-1];
        w_dvd  = {i_h, i_l};
        n1_side        = '0;
        n1_side.valid  = i_valid;
        n1_side.sym    = w_sym;
        n1_side.flr    = w_flr;
        n1_side.qneg   = w_sym & (w_hneg ^ w_dneg);
        n1_side.rneg   = w_sym ? w_hneg : (w_flr & w_dneg);
        n1_side.status = ST_OK;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_side <= '0;
        end else begin
            r1_side <= n1_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((w_sym && w_hneg) || (w_flr && w_dneg)) begin
            r1_dvd <= (2*W)'(-w_dvd);
        end else begin
            r1_dvd <= w_dvd;
        end
        if ((w_sym || w_flr) && w_dneg) begin
            r1_d <= W'(-i_d);
        end else begin
            r1_d <= i_d;
        end
    end

    // Stage 2: floored offset, zero and range checks.
    always_comb begin
        w_nneg = r1_side.flr & r1_dvd[2*W-1];
        w_h2   = w_nneg ? W'(r1_dvd[2*W-1:W] + r1_d) : r1_dvd[2*W-1:W];
        n2_side      = r1_side;
        n2_side.nneg = w_nneg;
        priority if (r1_d == '0) begin
            n2_side.status = ST_DIV_ZERO;
        end else if (w_h2 >= r1_d) begin
            n2_side.status = ST_RANGE;
        end else begin
            n2_side.status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_side <= '0;
        end else begin
            r2_side <= n2_side;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_h <= w_h2;
        r2_l <= r1_dvd[W-1:0];
        r2_d <= r1_d;
    end

    assign o_h    = r2_h;
    assign o_l    = r2_l;
    assign o_d    = r2_d;
    assign o_side = r2_side;

endmodule

@@ hdl/mpd_step.sv @@
// ============================================================================
// mpd_step
// One restoring shift-and-subtract step, registered: one quotient bit.
// ============================================================================
module mpd_step #(
    parameter int W = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [W-1:0]   i_rem,
    input  logic [W-1:0]   i_lq,
    input  logic [W-1:0]   i_d,
    input  mpd_pkg::t_side i_side,
    output logic [W-1:0]   o_rem,
    output logic [W-1:0]   o_lq,
    output logic [W-1:0]   o_d,
    output mpd_pkg::t_side o_side
);
    import mpd_pkg::*;

    logic [W:0]   w_wide;
    logic [W:0]   w_diff;
    logic         w_ge;
    logic [W-1:0] n_rem;
    logic [W-1:0] n_lq;
    logic [W-1:0] r_rem;
    logic [W-1:0] r_lq;
    logic [W-1:0] r_d;
    t_side        r_side;

    // Shift the next dividend bit in; subtract when it fits.
    always_comb begin
        w_wide = {i_rem, i_lq[W-1]};
        w_diff = w_wide - {1'b0, i_d};
        w_ge   = (w_wide >= {1'b0, i_d});
        n_rem  = w_ge ? w_diff[W-1:0] : w_wide[W-1:0];
        n_lq   = {i_lq[W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= '0;
        end else begin
            r_side <= i_side;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_lq  <= n_lq;
        r_d   <= i_d;
    end

    assign o_rem  = r_rem;
    assign o_lq   = r_lq;
    assign o_d    = r_d;
    assign o_side = r_side;

endmodule

@@ hdl/mpd_post.sv @@
// ============================================================================
// mpd_post
// Output stage: restore signs, check the signed quotient range, zero the
// fields of a failed item and register the result.
// ============================================================================
module mpd_post #(
    parameter int W = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [W-1:0]   i_q,
    input  logic [W-1:0]   i_r,
    input  mpd_pkg::t_side i_side,
    output logic           o_strobe,
    output logic [W-1:0]   o_quotient,
    output logic [W-1:0]   o_remainder,
    output logic [1:0]     o_status
);
    import mpd_pkg::*;

    logic [W-1:0] w_nq;
    logic [W-1:0] w_qf;
    logic [W-1:0] w_rf;
    logic         w_ovf;
    logic [1:0]   n_status;
    logic         r_strobe;
    logic [W-1:0] r_quotient;
    logic [W-1:0] r_remainder;
    logic [1:0]   r_status;

    always_comb begin
        w_nq  = W'(-i_q);
        w_qf  = i_q;
        w_ovf = 1'b0;
        if (i_side.sym) begin
            if (i_side.qneg) begin
                w_qf  = w_nq;
                w_ovf = !w_nq[W-1] && (i_q != '0);
            end else begin
                w_ovf = i_q[W-1];
            end
        end else if (i_side.flr) begin
            w_ovf = (i_side.nneg != i_q[W-1]);
        end
        w_rf = i_side.rneg ? W'(-i_r) : i_r;
        priority if (i_side.status != ST_OK) begin
            n_status = i_side.status;
        end else if (w_ovf) begin
            n_status = ST_RANGE;
        end else begin
            n_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_side.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        if (n_status == ST_OK) begin
            r_quotient  <= w_qf;
            r_remainder <= w_rf;
        end else begin
            r_quotient  <= '0;
            r_remainder <= '0;
        end
    end

    assign o_strobe    = r_strobe;
    assign o_quotient  = r_quotient;
    assign o_remainder = r_remainder;
    assign o_status    = r_status;

endmodule
